@@ hdl/fmpc_pkg.sv @@
// Package for the first-match packet classifier.
// Holds the word types, opcodes and status codes; no dependencies.
package fmpc_pkg;
  localparam logic [2:0] OP_CLASSIFY = 3'd0;
  localparam logic [2:0] OP_ADD      = 3'd1;
  localparam logic [2:0] OP_DELETE   = 3'd2;
  localparam logic [2:0] OP_DOWN     = 3'd3;
  localparam logic [2:0] OP_UP       = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;

  // Low tag bits that are kept on add and compared on delete and move.
  localparam int         TAG_BITS = 8;
  localparam logic [7:0] TAG_MASK = 8'((16'd1 << TAG_BITS) - 16'd1);

  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [7:0]  protocol;
    logic [7:0]  tos;
    logic [5:0]  src_prefix_len;
    logic [5:0]  dst_prefix_len;
    logic [7:0]  rule_tag;
  } in_word_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] match_tag;
    logic [1:0] status;
  } out_word_t;

  typedef struct packed {
    logic [31:0] src;
    logic [31:0] dst;
    logic [5:0]  slen;
    logic [5:0]  dlen;
    logic [7:0]  prot;
    logic [7:0]  tosv;
    logic [7:0]  tag;
  } rule_t;

  // Per-cell table update, set by the controller for each cell.
  typedef struct packed {
    logic load;     // take the rule on new_rule
    logic shr;      // take left neighbor's rule
    logic shl;      // take right neighbor's rule
  } cell_ctl_t;

  function automatic logic [31:0] prefix_mask(input logic [5:0] len);
    logic [31:0] m;
    m = '0;
    if (len >= 6'd32) m = '1;
    else if (len != 6'd0) m = ~(32'hFFFF_FFFF >> len[4:0]);
    return m;
  endfunction
endpackage

@@ hdl/fmpc_cell.sv @@
// One rule slot of the classifier chain: holds a rule, matches it and passes
// rules to its neighbors on shifts. Depends on fmpc_pkg.
module fmpc_cell (
  input  logic              clk,
  input  fmpc_pkg::rule_t   new_rule,
  input  fmpc_pkg::rule_t   left_rule,
  input  fmpc_pkg::rule_t   right_rule,
  input  fmpc_pkg::cell_ctl_t ctl,
  input  fmpc_pkg::in_word_t key,
  output fmpc_pkg::rule_t   rule,
  output logic              match,
  output logic              tag_eq
);
  fmpc_pkg::rule_t rule_r;

  always_ff @(posedge clk) begin
    if (ctl.load) rule_r <= new_rule;
    else if (ctl.shr) rule_r <= left_rule;
    else if (ctl.shl) rule_r <= right_rule;
  end

  assign rule = rule_r;
  assign match = ((key.src_addr & fmpc_pkg::prefix_mask(rule_r.slen)) == rule_r.src)
              && ((key.dst_addr & fmpc_pkg::prefix_mask(rule_r.dlen)) == rule_r.dst)
              && (rule_r.prot == 8'd0 || rule_r.prot == key.protocol)
              && (rule_r.tosv == 8'd0 || rule_r.tosv == key.tos);
  assign tag_eq = rule_r.tag == key.rule_tag;
endmodule

@@ hdl/first_match_packet_classifier.sv @@
// Top level of the first-match packet classifier: controller plus cell chain.
// Depends on fmpc_pkg and fmpc_cell.
//
// Start is taken when busy is low, and busy is
// then high for one cycle in which the key is matched against all cells
// through a priority pick and any table update is applied to the chain. The
// result is registered and shows on out_valid in the following cycle; the
// next word can be taken at the edge that ends that cycle, so no word is
// accepted while busy is high. Table updates move whole rules one cell along
// the chain (a wrapping move rotates a span of cells, the far-end rule going
// straight to cell 0 or to the last used cell), so the update finishes in the
// busy cycle for every opcode. No result can be held off.
module first_match_packet_classifier #(
  parameter int MAX_RULES = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  fmpc_pkg::in_word_t   in_word,
  output logic                 out_valid,
  output fmpc_pkg::out_word_t  out_word
);
  localparam int CW = $clog2(MAX_RULES + 1);
  localparam int IW = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;

  logic [CW-1:0] count_r, count_nxt;
  logic busy_r;
  fmpc_pkg::in_word_t key_r;
  fmpc_pkg::rule_t new_rule;
  fmpc_pkg::rule_t head_rule;
  fmpc_pkg::rule_t rules [MAX_RULES];
  fmpc_pkg::cell_ctl_t ctl [MAX_RULES];
  logic [MAX_RULES-1:0] match_v, tag_v;
  logic hit;
  logic [IW-1:0] hit_i, tag_i;
  logic found;
  fmpc_pkg::out_word_t res;

  always_comb begin
    new_rule.src  = key_r.src_addr;
    new_rule.dst  = key_r.dst_addr;
    new_rule.slen = key_r.src_prefix_len;
    new_rule.dlen = key_r.dst_prefix_len;
    new_rule.prot = key_r.protocol;
    new_rule.tosv = key_r.tos;
    new_rule.tag  = key_r.rule_tag & fmpc_pkg::TAG_MASK;
  end

  // Cell 0 takes the new rule on add, or the last rule on a wrapping move down.
  assign head_rule = (key_r.opcode == fmpc_pkg::OP_DOWN) ? rules[tag_i] : new_rule;

  for (genvar g = 0; g < MAX_RULES; g++) begin : g_cell
    fmpc_pkg::in_word_t k;
    always_comb begin
      k = key_r;
      k.rule_tag = new_rule.tag;
    end
    fmpc_cell u_cell (
      .clk(clk), .new_rule((g == 0) ? head_rule : rules[0]),
      .left_rule(rules[(g + MAX_RULES - 1) % MAX_RULES]),
      .right_rule(rules[(g + 1) % MAX_RULES]),
      .ctl(ctl[g]), .key(k), .rule(rules[g]),
      .match(match_v[g]), .tag_eq(tag_v[g])
    );
  end

  always_comb begin
    hit = 1'b0; hit_i = '0; found = 1'b0; tag_i = '0;
    for (int i = MAX_RULES - 1; i >= 0; i--) begin
      if (i < count_r && match_v[i]) begin
        hit = 1'b1; hit_i = IW'(i);
      end
      if (i < count_r && tag_v[i]) begin
        found = 1'b1; tag_i = IW'(i);
      end
    end
  end

  always_comb begin
    logic [CW-1:0] p, n;
    p = CW'(tag_i);
    n = count_r;
    count_nxt = count_r;
    res = '0;
    for (int i = 0; i < MAX_RULES; i++) ctl[i] = '0;
    if (busy_r) begin
      unique case (key_r.opcode) inside
        fmpc_pkg::OP_CLASSIFY: begin
          res.hit = hit;
          res.match_tag = hit ? rules[hit_i].tag : 8'd0;
        end
        fmpc_pkg::OP_ADD: begin
          if (n >= CW'(MAX_RULES)) res.status = fmpc_pkg::ST_FULL;
          else begin
            ctl[0].load = 1'b1;
            for (int i = 1; i < MAX_RULES; i++) ctl[i].shr = (i <= n);
            count_nxt = n + 1'b1;
          end
        end
        fmpc_pkg::OP_DELETE, fmpc_pkg::OP_DOWN, fmpc_pkg::OP_UP: begin
          if (!found) res.status = fmpc_pkg::ST_NOTFOUND;
          else if (key_r.opcode == fmpc_pkg::OP_DELETE) begin
            for (int i = 0; i < MAX_RULES; i++) ctl[i].shl = (i >= p) && (i + 1 < n);
            count_nxt = n - 1'b1;
          end else if (n > 1) begin
            if (key_r.opcode == fmpc_pkg::OP_DOWN) begin
              if (p + 1'b1 < n) begin
                for (int i = 0; i < MAX_RULES; i++) begin
                  ctl[i].shl = (i == p);
                  ctl[i].shr = (i == p + 1'b1);
                end
              end else begin
                for (int i = 0; i < MAX_RULES; i++) begin
                  ctl[i].load = (i == 0);
                  ctl[i].shr = (i != 0) && (i <= p);
                end
              end
            end else begin
              if (p > 0) begin
                for (int i = 0; i < MAX_RULES; i++) begin
                  ctl[i].shr = (i == p);
                  ctl[i].shl = (i + 1 == p);
                end
              end else begin
                for (int i = 0; i < MAX_RULES; i++) begin
                  ctl[i].shl = (i + 1 < n);
                  ctl[i].load = (i + 1 == n);
                end
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      count_r <= '0;
      out_valid <= 1'b0;
    end else begin
      busy_r  <= start && !busy_r;
      count_r <= count_nxt;
      out_valid <= busy_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) key_r <= in_word;
    if (busy_r) out_word <= res;
  end

  assign busy = busy_r;

  a_valid_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy_r));
  a_busy_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |=> !busy_r);
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_RULES));
endmodule

@@ tb/fmpc_checker.sv @@
// Checker for the first-match packet classifier: watches the command and
// result ports, keeps its own rule table and compares every result word.
// Depends on fmpc_pkg.
module fmpc_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  fmpc_pkg::in_word_t  in_word,
  input  logic                out_valid,
  input  fmpc_pkg::out_word_t out_word,
  output int                  fail_count,
  output int                  pending
);
  localparam int NRULES = 16;

  fmpc_pkg::rule_t     rules[NRULES];
  int                  nrules;
  fmpc_pkg::out_word_t want_q[$];

  assign pending = want_q.size();

  function automatic logic [31:0] len_mask(logic [5:0] len);
    logic [31:0] m;
    m = '0;
    if (len >= 6'd32) m = '1;
    else if (len != 6'd0) m = 32'hFFFF_FFFF << (6'd32 - len);
    return m;
  endfunction

  function automatic int tag_pos(logic [7:0] tag);
    for (int i = 0; i < nrules; i++)
      if (rules[i].tag == tag) return i;
    return -1;
  endfunction

  task automatic classify_word(input fmpc_pkg::in_word_t w,
                               output fmpc_pkg::out_word_t r);
    fmpc_pkg::rule_t t;
    int p;
    r = '0;
    r.status = fmpc_pkg::ST_OK;
    case (w.opcode) inside
      fmpc_pkg::OP_CLASSIFY: begin
        for (int i = 0; i < nrules; i++) begin
          if ((w.src_addr & len_mask(rules[i].slen)) != rules[i].src) continue;
          if ((w.dst_addr & len_mask(rules[i].dlen)) != rules[i].dst) continue;
          if (rules[i].prot != 0 && rules[i].prot != w.protocol) continue;
          if (rules[i].tosv != 0 && rules[i].tosv != w.tos) continue;
          r.hit = 1'b1;
          r.match_tag = rules[i].tag;
          break;
        end
      end
      fmpc_pkg::OP_ADD: begin
        if (nrules >= NRULES) r.status = fmpc_pkg::ST_FULL;
        else begin
          for (int i = nrules; i > 0; i--) rules[i] = rules[i-1];
          rules[0] = '{w.src_addr, w.dst_addr, w.src_prefix_len, w.dst_prefix_len,
                       w.protocol, w.tos, w.rule_tag & fmpc_pkg::TAG_MASK};
          nrules++;
        end
      end
      fmpc_pkg::OP_DELETE, fmpc_pkg::OP_DOWN, fmpc_pkg::OP_UP: begin
        p = tag_pos(w.rule_tag & fmpc_pkg::TAG_MASK);
        if (p < 0) r.status = fmpc_pkg::ST_NOTFOUND;
        else if (w.opcode == fmpc_pkg::OP_DELETE) begin
          for (int i = p; i + 1 < nrules; i++) rules[i] = rules[i+1];
          nrules--;
        end else if (nrules > 1) begin
          if (w.opcode == fmpc_pkg::OP_DOWN) begin
            if (p + 1 < nrules) begin
              t = rules[p]; rules[p] = rules[p+1]; rules[p+1] = t;
            end else begin
              t = rules[p];
              for (int i = p; i > 0; i--) rules[i] = rules[i-1];
              rules[0] = t;
            end
          end else begin
            if (p > 0) begin
              t = rules[p]; rules[p] = rules[p-1]; rules[p-1] = t;
            end else begin
              t = rules[0];
              for (int i = 0; i + 1 < nrules; i++) rules[i] = rules[i+1];
              rules[nrules-1] = t;
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    fmpc_pkg::out_word_t r;
    fmpc_pkg::out_word_t w;
    if (!rst_n) begin
      nrules = 0;
      fail_count = 0;
      want_q.delete();
    end else begin
      if (out_valid) begin
        if (want_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result word %p", out_word);
        end else begin
          w = want_q.pop_front();
          if (out_word.hit !== w.hit || out_word.match_tag !== w.match_tag ||
              out_word.status !== w.status) begin
            fail_count++;
            if (fail_count <= 10)
              $display("result mismatch: expected %p, got %p", w, out_word);
          end
        end
      end
      if (start && !busy) begin
        classify_word(in_word, r);
        want_q.push_back(r);
      end
    end
  end
endmodule

@@ tb/tb.sv @@
// Testbench top for the first-match packet classifier: drives command words
// with random gaps and gives the verdict. Depends on fmpc_pkg, the block and
// fmpc_checker.
module tb;
  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  fmpc_pkg::in_word_t  in_word = '0;
  logic                out_valid;
  fmpc_pkg::out_word_t out_word;
  int                  fail_count;
  int                  pending;
  int                  cycles = 0;
  int                  idle_pct = 0;
  logic [7:0]          tags[$];

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  first_match_packet_classifier u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_word(in_word), .out_valid(out_valid), .out_word(out_word)
  );

  fmpc_checker u_chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_word(in_word),
    .out_valid(out_valid), .out_word(out_word),
    .fail_count(fail_count), .pending(pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 200000) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic logic [31:0] mask_of(logic [5:0] len);
    if (len == 0) return '0;
    if (len >= 32) return '1;
    return 32'hFFFF_FFFF << (6'd32 - len);
  endfunction

  // Hold the word until the block takes it, with random leading gaps.
  task automatic send(input fmpc_pkg::in_word_t w);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) @(negedge clk);
    in_word = w;
    start = 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    start = 1'b0;
  endtask

  function automatic logic [7:0] pick_tag();
    if (tags.size() != 0 && $urandom_range(9) < 8)
      return tags[$urandom_range(tags.size() - 1)];
    return 8'($urandom_range(15));
  endfunction

  task automatic rand_word(output fmpc_pkg::in_word_t w);
    int k;
    w.opcode = 3'($urandom_range(7));
    w.src_addr = $urandom;
    w.dst_addr = $urandom;
    w.protocol = $urandom_range(3) == 0 ? 8'($urandom) : 8'($urandom_range(3));
    w.tos = $urandom_range(3) == 0 ? 8'($urandom) : 8'($urandom_range(3));
    w.src_prefix_len = $urandom_range(9) == 0 ? 6'($urandom) : 6'($urandom_range(32));
    w.dst_prefix_len = $urandom_range(9) == 0 ? 6'($urandom) : 6'($urandom_range(32));
    w.rule_tag = pick_tag();
    k = $urandom_range(99);
    if (k < 45) w.opcode = fmpc_pkg::OP_CLASSIFY;
    else if (k < 65) w.opcode = fmpc_pkg::OP_ADD;
    else if (k < 75) w.opcode = fmpc_pkg::OP_DELETE;
    else if (k < 85) w.opcode = fmpc_pkg::OP_DOWN;
    else if (k < 95) w.opcode = fmpc_pkg::OP_UP;
    if (w.opcode == fmpc_pkg::OP_ADD) begin
      if ($urandom_range(9) != 0) begin
        w.src_addr &= mask_of(w.src_prefix_len);
        w.dst_addr &= mask_of(w.dst_prefix_len);
      end
      tags.push_back(w.rule_tag);
      if (tags.size() > 24) void'(tags.pop_front());
    end else if (w.opcode == fmpc_pkg::OP_CLASSIFY && $urandom_range(3) != 0) begin
      // Aim at the high bits that short rule prefixes use.
      w.src_addr = {$urandom_range(3) == 0 ? 4'($urandom) : 4'($urandom_range(1)),
                    28'($urandom)};
      w.dst_addr = {$urandom_range(3) == 0 ? 4'($urandom) : 4'($urandom_range(1)),
                    28'($urandom)};
    end
  endtask

  task automatic directed();
    fmpc_pkg::in_word_t w;
    w = '0;
    w.opcode = fmpc_pkg::OP_CLASSIFY; send(w);
    w.opcode = fmpc_pkg::OP_DELETE; w.rule_tag = 8'd9; send(w);
    w.opcode = fmpc_pkg::OP_DOWN; send(w);
    w.opcode = fmpc_pkg::OP_UP; send(w);
    w = '0; w.opcode = fmpc_pkg::OP_ADD; w.rule_tag = 8'hFF; send(w);
    w.opcode = fmpc_pkg::OP_DOWN; send(w);
    w.opcode = fmpc_pkg::OP_UP; send(w);
    w = '0; w.opcode = fmpc_pkg::OP_CLASSIFY; w.src_addr = '1; w.dst_addr = '1;
    w.protocol = 8'hFF; w.tos = 8'hFF; send(w);
    w = '0; w.opcode = fmpc_pkg::OP_ADD; w.src_addr = 32'hC0A8_0000;
    w.src_prefix_len = 6'd16;
    w.dst_addr = 32'hFFFF_FFFF; w.dst_prefix_len = 6'd63; w.protocol = 8'd6;
    w.tos = 8'h80; w.rule_tag = 8'd1; send(w);
    w = '0; w.opcode = fmpc_pkg::OP_ADD; w.src_addr = 32'h8000_0001;
    w.src_prefix_len = 6'd1;
    w.rule_tag = 8'd2; send(w);
    w = '0; w.opcode = fmpc_pkg::OP_CLASSIFY; w.src_addr = 32'hC0A8_1234;
    w.dst_addr = '1;
    w.protocol = 8'd6; w.tos = 8'h80; send(w);
    w.protocol = 8'd17; send(w);
    w.opcode = 3'd7; send(w);
    w = '0; w.opcode = fmpc_pkg::OP_DOWN; w.rule_tag = 8'd1; send(w);
    w.opcode = fmpc_pkg::OP_UP; w.rule_tag = 8'd2; send(w);
    w.opcode = fmpc_pkg::OP_DELETE; w.rule_tag = 8'd1; send(w);
    for (int i = 0; i < 17; i++) begin
      w = '0; w.opcode = fmpc_pkg::OP_ADD; w.rule_tag = 8'(i + 3); w.protocol = 8'(i);
      send(w);
    end
    w = '0; w.opcode = fmpc_pkg::OP_CLASSIFY; w.protocol = 8'd5; send(w);
    w.opcode = 3'd5; send(w);
    for (int i = 0; i < 17; i++) begin
      w = '0; w.opcode = fmpc_pkg::OP_DELETE; w.rule_tag = 8'(i + 2); send(w);
    end
  endtask

  initial begin
    fmpc_pkg::in_word_t w;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    directed();
    for (int n = 0; n < 1350; n++) begin
      case (n / 270)
        0: idle_pct = 0;
        1: idle_pct = 48;
        2: idle_pct = 0;
        3: idle_pct = 23;
        default: idle_pct = $urandom_range(1) ? 0 : 48;
      endcase
      if (n == 700) begin
        while (pending != 0) @(negedge clk);
      end
      rand_word(w);
      send(w);
    end
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (fail_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end
endmodule

@@ files.f @@
hdl/fmpc_pkg.sv
hdl/fmpc_cell.sv
hdl/first_match_packet_classifier.sv
tb/fmpc_checker.sv
tb/tb.sv
